FILE: hw/rtl/signed_base62_text_encoder_defines.svh
// ----------------------------------------------------------------------------
// Signed base62 text encoder: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BASE62_TEXT_ENCODER_DEFINES_SVH
`define SIGNED_BASE62_TEXT_ENCODER_DEFINES_SVH

// Same-cycle implication
`define SB62_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sb62 check failed: same-cycle implication");

// Next-cycle implication
`define SB62_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sb62 check failed: next-cycle implication");

`endif

FILE: hw/rtl/sb62_pkg.sv
// ----------------------------------------------------------------------------
// sb62_pkg
// Types, constants and the digit alphabet of the signed base62 text encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sb62_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned CapW      = 8;
  localparam int unsigned MaxDigits = 6;   // 62^6 exceeds 2^31
  localparam int unsigned CntW      = 3;   // holds 0..MaxDigits
  localparam int unsigned RemW      = 6;   // one base62 digit

  // floor(x / 31) = (x * RecipM) >> RecipShift for every x below 2^31
  localparam logic [31:0] RecipM     = 32'd2216757315;
  localparam int unsigned RecipShift = 36;
  localparam int unsigned ProdW      = 63;
  localparam int unsigned QuoW       = ProdW - RecipShift;

  localparam logic [CapW-1:0]  CapReset  = 8'd8;
  localparam logic [CharW-1:0] MinusChar = 8'h2D;
  localparam logic [CharW-1:0] FailChar  = 8'h00;

  // Character selected onto the result word
  typedef enum logic [1:0] {
    SEL_SIGN  = 2'd0,
    SEL_DIGIT = 2'd1,
    SEL_FAIL  = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic     load;   // capture a new value
    logic     step;   // peel off one digit
    logic     pop;    // drop the top digit after it is sent
    out_sel_e sel;
  } sb62_cmd_t;

  typedef struct packed {
    logic quo_zero;   // quotient of this step is zero: last digit found
    logic fits;       // text plus terminator fits the buffer
    logic neg;        // value is negative
    logic last_digit; // one digit left on the stack
  } sb62_status_t;

  // Map a digit to '0'-'9', 'a'-'z', 'A'-'Z'
  function automatic logic [CharW-1:0] digit_char(input logic [RemW-1:0] r);
    logic [CharW-1:0] ch;
    case (r) inside
      [6'd0:6'd9]:   ch = 8'h30 + {2'b00, r};
      [6'd10:6'd35]: ch = 8'h57 + {2'b00, r};
      [6'd36:6'd61]: ch = 8'h1D + {2'b00, r};
      default:       ch = FailChar;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sb62_ctrl.sv
// ----------------------------------------------------------------------------
// sb62_ctrl
// Sequencer: accept a word, run the digit loop, check the fit, send the text.
// ----------------------------------------------------------------------------
`default_nettype none

module sb62_ctrl
  import sb62_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic              last_o,
  output logic              fail_o,
  input  wire sb62_status_t status_i,
  output sb62_cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_CHECK = 6'b000100,
    S_SIGN  = 6'b001000,
    S_DIGIT = 6'b010000,
    S_FAIL  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '{load: 1'b0, step: 1'b0, pop: 1'b0, sel: SEL_DIGIT};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    last_o      = 1'b0;
    fail_o      = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.quo_zero) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status_i.fits) begin
          state_d = S_FAIL;
        end else if (status_i.neg) begin
          state_d = S_SIGN;
        end else begin
          state_d = S_DIGIT;
        end
      end
      S_SIGN: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_SIGN;
        if (out_ready_i) begin
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        out_valid_o = 1'b1;
        last_o      = status_i.last_digit;
        if (out_ready_i) begin
          cmd_o.pop = 1'b1;
          if (status_i.last_digit) begin
            state_d = S_IDLE;
          end
        end
      end
      S_FAIL: begin
        out_valid_o = 1'b1;
        last_o      = 1'b1;
        fail_o      = 1'b1;
        cmd_o.sel   = SEL_FAIL;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sb62_dp.sv
// ----------------------------------------------------------------------------
// sb62_dp
// Datapath: magnitude, divide-by-62 step, digit stack, capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module sb62_dp
  import sb62_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CapW-1:0]   cfg_wdata_i,
  input  wire logic [ValueW-1:0] value_i,
  input  wire sb62_cmd_t         cmd_i,
  output sb62_status_t           status_o,
  output logic [CharW-1:0]       character_o
);

  logic [CapW-1:0]   cap_q;
  logic              neg_q;
  logic [ValueW-1:0] cur_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CharW-1:0]  stk_q [MaxDigits];

  logic [ProdW-1:0]  prod;
  logic [QuoW-1:0]   quo;
  logic [RemW-1:0]   rem;
  logic [CapW-1:0]   needed;

  // Hold the buffer capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Divide by 62: halve, then multiply by the reciprocal of 31.
  // The remainder is below 64, so only its low six bits are formed.
  assign prod = ProdW'(cur_q[ValueW-1:1]) * ProdW'(RecipM);
  assign quo  = prod[ProdW-1:RecipShift];
  assign rem  = cur_q[RemW-1:0] + {quo[RemW-2:0], 1'b0};

  // Digit counter
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end else if (cmd_i.step) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Load the magnitude, advance the quotient
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= value_i[ValueW-1];
      cur_q <= value_i[ValueW-1] ? (~value_i + ValueW'(1)) : value_i;
    end else if (cmd_i.step) begin
      cur_q <= ValueW'(quo);
    end
  end

  // Push digits least significant first, pop most significant first
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      stk_q[0] <= digit_char(rem);
      for (int i = 1; i < MaxDigits; i++) begin
        stk_q[i] <= stk_q[i-1];
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < MaxDigits - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
  end

  // Fit check: digits, sign and terminator against capacity
  assign needed = CapW'(cnt_q) + CapW'(neg_q) + CapW'(1);

  assign status_o.quo_zero   = (quo == '0);
  assign status_o.fits       = (needed <= cap_q);
  assign status_o.neg        = neg_q;
  assign status_o.last_digit = (cnt_q == CntW'(1));

  // Select the outgoing character
  always_comb begin
    case (cmd_i.sel)
      SEL_SIGN:  character_o = MinusChar;
      SEL_DIGIT: character_o = stk_q[0];
      SEL_FAIL:  character_o = FailChar;
      default:   character_o = FailChar;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/signed_base62_text_encoder.sv
// ----------------------------------------------------------------------------
// signed_base62_text_encoder
// Encodes a signed 32-bit word as base62 ASCII text, one character a word.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o  | value_i
//   out     | output    | out_valid_o / out_ready_i| character_o, last_o, fail_o
//   cfg     | input     | cfg_we_i                 | cfg_wdata_i (buffer capacity)
//
// An input word is accepted, its base62 digits (1 to 6) are peeled off one
// at a time through the single divide-by-62 multiplier, the fit is checked,
// and then the result words (1 to 7) are sent.
// Reset sets the capacity to 8 and returns the sequencer to idle.
// A stalled output holds its word; no input is taken until the run ends.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_base62_text_encoder
  import sb62_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CapW-1:0]   cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CharW-1:0]       character_o,
  output logic                   last_o,
  output logic                   fail_o
);

  sb62_cmd_t    cmd;
  sb62_status_t status;

  // Sequencer
  sb62_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .last_o      (last_o),
    .fail_o      (fail_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath
  sb62_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .character_o (character_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/sb62_chk.sv
// ----------------------------------------------------------------------------
// sb62_chk
// Port-level checks of the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_base62_text_encoder_defines.svh"

module sb62_chk
  import sb62_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [CharW-1:0] character_i,
  input wire logic             last_i,
  input wire logic             fail_i
);

  // A failure word is a lone, empty, final word
  `SB62_ASSERT_IMP(a_fail_is_last, out_valid_i && fail_i, last_i && character_i == FailChar)

  // Never take input while a run is being sent
  `SB62_ASSERT_IMP(a_no_overlap, 1'b1, !(in_ready_i && out_valid_i))

  // A run ends with its last word
  `SB62_ASSERT_NXT(a_end_of_run, out_valid_i && out_ready_i && last_i, !out_valid_i)

  // Stalled output word holds
  `SB62_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(character_i) && $stable(last_i))

  // Offered input word stays offered until taken
  `SB62_ASSERT_NXT(a_in_hold, in_valid_i && !in_ready_i, in_valid_i)

endmodule

bind signed_base62_text_encoder sb62_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .character_i (character_o),
  .last_i      (last_o),
  .fail_i      (fail_o)
);

`default_nettype wire

FILE: bench/sb62_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb62_text_checker
// Watches the config, input and output channels of the signed base62 text
// encoder. Each accepted input word is expanded into the text words it should
// produce, and each accepted output word is compared with the oldest of them.
// ----------------------------------------------------------------------------

module sb62_text_checker
  import sb62_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CapW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [ValueW-1:0] value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CharW-1:0]  character_i,
  input  logic              last_i,
  input  logic              fail_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o
);

  localparam int unsigned Radix = 62;
  localparam logic [CharW-1:0] AsciiZero   = 8'h30;
  localparam logic [CharW-1:0] AsciiLowerA = 8'h61;
  localparam logic [CharW-1:0] AsciiUpperA = 8'h41;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
    logic             fail;
  } text_word_t;

  text_word_t      text_queue[$];
  logic [CapW-1:0] capacity;
  int unsigned     mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Map one base62 digit onto 0-9, a-z, A-Z
  function automatic logic [CharW-1:0] digit_to_ascii(input int unsigned d);
    if (d < 10) begin
      return AsciiZero + CharW'(d);
    end else if (d < 36) begin
      return AsciiLowerA + CharW'(d - 10);
    end
    return AsciiUpperA + CharW'(d - 36);
  endfunction

  // Expand one value into its expected text words, or a single fail word
  task automatic expand_to_text(input logic [ValueW-1:0] v);
    logic             neg;
    logic [ValueW-1:0] mag;
    logic [CharW-1:0] digits[$];
    int unsigned      needed;
    neg = v[ValueW-1];
    mag = neg ? -v : v;
    // peel digits least significant first; zero still yields one digit
    do begin
      digits.push_back(digit_to_ascii(mag % Radix));
      mag = mag / Radix;
    end while (mag != 0);
    // digits, sign and terminator slot must fit; this also covers capacity below two
    needed = digits.size() + (neg ? 1 : 0) + 1;
    if (needed > capacity) begin
      text_queue.push_back({FailChar, 1'b1, 1'b1});
      return;
    end
    if (neg) begin
      text_queue.push_back({MinusChar, 1'b0, 1'b0});
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      text_queue.push_back({digits[i], (i == 0), 1'b0});
    end
  endtask

  // Track the capacity, predict on accepted inputs, compare accepted outputs
  always @(posedge clk_i or negedge rst_ni) begin : watch
    text_word_t want;
    if (!rst_ni) begin
      capacity = CapReset;
      text_queue.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        capacity = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        expand_to_text(value_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (text_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected word char 0x%02h last %0b fail %0b",
                                    character_i, last_i, fail_i));
        end else begin
          want = text_queue.pop_front();
          if (character_i !== want.ch) begin
            report_mismatch($sformatf("char 0x%02h, want 0x%02h", character_i, want.ch));
          end
          if (last_i !== want.last) begin
            report_mismatch($sformatf("last %0b, want %0b (char 0x%02h)",
                                      last_i, want.last, want.ch));
          end
          if (fail_i !== want.fail) begin
            report_mismatch($sformatf("fail %0b, want %0b (char 0x%02h)",
                                      fail_i, want.fail, want.ch));
          end
        end
      end
      pending_o <= text_queue.size();
    end
  end

endmodule

FILE: bench/tb_signed_base62_text_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_base62_text_encoder
// Drives corner values and random values of every digit count through the
// encoder across a range of buffer capacities, with random gaps on both
// channels and one long output stall. The checker judges every output word.
// ----------------------------------------------------------------------------

module tb_signed_base62_text_encoder;
  import sb62_pkg::*;

  localparam int unsigned Radix        = 62;
  localparam int unsigned IdlePct      = 25;
  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned PhaseItems   = 22;
  localparam int unsigned NumPhases    = 12;
  localparam int unsigned FixedPhases  = 10;
  localparam int unsigned QuietPhase   = 9;
  localparam int unsigned SettleCycles = 3;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned NumCorners   = 23;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [CapW-1:0]   cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [ValueW-1:0] value;
  logic              out_valid;
  logic              out_ready;
  logic [CharW-1:0]  text_char;
  logic              text_last;
  logic              text_fail;
  int unsigned       mismatches;
  int unsigned       pending;
  logic              quiet = 1'b0;
  logic              hold_req = 1'b0;

  logic [ValueW-1:0] corner_values [NumCorners] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, 32'd35, 32'd36, 32'd61, -32'sd61,
    32'd62, -32'sd62, 32'd3843, 32'd3844, 32'd238327, 32'd238328,
    32'd14776335, 32'd14776336, 32'd916132831, 32'd916132832, -32'sd916132832,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001
  };

  logic [CapW-1:0] cap_plan [FixedPhases] = '{
    8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8
  };

  signed_base62_text_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .character_o (text_char),
    .last_o      (text_last),
    .fail_o      (text_fail)
  );

  sb62_text_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .character_i  (text_char),
    .last_i       (text_last),
    .fail_i       (text_fail),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random value: full range, a corner, or a magnitude with a chosen digit count
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned     ndig;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    case ($urandom_range(9))
      0, 1: return $urandom();
      2: return corner_values[$urandom_range(NumCorners - 1)];
      default: begin
        ndig = $urandom_range(1, 6);
        hi = 1;
        repeat (ndig) hi = hi * Radix;
        lo = (ndig == 1) ? 0 : hi / Radix;
        hi = (hi - 1 > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : hi - 1;
        mag = lo + ($urandom() % (hi - lo + 1));
        return $urandom_range(1) ? -mag[31:0] : mag[31:0];
      end
    endcase
  endfunction

  // Offer one word, with random idle cycles ahead of it, and hold until taken
  task automatic send_word(input logic [ValueW-1:0] v);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the buffer capacity for one cycle
  task automatic write_capacity(input logic [CapW-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Sender: corners at reset capacity, then random words per capacity phase
  initial begin : sender
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    value     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_values[i]) send_word(corner_values[i]);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      write_capacity((p < FixedPhases) ? cap_plan[p] : CapW'($urandom_range(255)));
      quiet = (p == QuietPhase);
      if (p == 0) begin
        hold_req = 1'b1;
      end
      repeat (PhaseItems) send_word(pick_value());
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("signed_base62_text_encoder verification clean");
    end else begin
      $display("signed_base62_text_encoder verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off while words pile up
  initial begin : receiver
    int unsigned held;
    logic        hold_done;
    held      = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        held++;
        if (held == HoldCycles) begin
          hold_done = 1'b1;
        end
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("signed_base62_text_encoder verification failed");
    $finish;
  end

endmodule
